[rtl/bsg_pkg.sv]
package bsg_pkg;

  localparam int BLOCK_DEPTH = 2048;
  localparam int SAMPLE_BITS = 16;

  localparam int IDX_W      = $clog2(BLOCK_DEPTH);
  localparam int ADDR_W     = IDX_W + 1;
  localparam int RAM_DEPTH  = 2 * BLOCK_DEPTH;
  localparam int WORD_W     = 2 * SAMPLE_BITS;
  localparam int SQ_W       = 2 * SAMPLE_BITS;
  localparam int PWR_W      = 2 * SAMPLE_BITS + IDX_W;
  localparam int THR_W      = 42;
  localparam int LEN_W      = 12;
  localparam int RECIP_W    = 25;
  localparam int GAIN_FRAC  = 24;
  localparam int GAIN_W     = GAIN_FRAC + 1;
  localparam int GPROD_W    = IDX_W + RECIP_W;
  localparam int PROD_W     = SAMPLE_BITS + GAIN_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 42;

  // compare widths wide enough for index + 1, lengths and depth
  localparam int CMP_W  = ((IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W) + 1;
  localparam int PCMP_W = (PWR_W > THR_W) ? PWR_W : THR_W;

  localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC{1'b0}}};

  localparam logic [THR_W-1:0]   THRESHOLD_RESET  = THR_W'(1073742);
  localparam logic [LEN_W-1:0]   BLOCK_LEN_RESET  = LEN_W'(2048);
  localparam logic [LEN_W-1:0]   RAMP_LEN_RESET   = LEN_W'(1896);
  localparam logic [RECIP_W-1:0] RAMP_RECIP_RESET = RECIP_W'(8849);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GATE_ENABLE,
    CFG_THRESHOLD_POWER,
    CFG_BLOCK_LEN,
    CFG_RAMP_LEN,
    CFG_RAMP_RECIP
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_FADE_OUT,
    MODE_ZERO,
    MODE_FADE_IN
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic               gate_enable;
    logic [THR_W-1:0]   threshold_power;
    logic [LEN_W-1:0]   block_len;
    logic [LEN_W-1:0]   ramp_len;
    logic [RECIP_W-1:0] ramp_recip;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic compute;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic primed;
  } stat_t;

endpackage

[rtl/bsg_ram.sv]
module bsg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/bsg_ctrl.sv]
module bsg_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  bsg_pkg::stat_t stat,
  output bsg_pkg::cmd_t  cmd
);

  bsg_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  // output register can take a word this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsg_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bsg_pkg::ST_READ;
        end
      end
      bsg_pkg::ST_READ: begin
        state_nxt = bsg_pkg::ST_UPDATE;
      end
      bsg_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_nxt = bsg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bsg_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd.accept  = 1'b0;
    cmd.compute = 1'b0;
    cmd.update  = 1'b0;
    case (state_r)
      bsg_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      bsg_pkg::ST_READ: begin
        cmd.compute = 1'b1;
      end
      bsg_pkg::ST_UPDATE: begin
        cmd.update = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update && stat.primed) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == bsg_pkg::ST_READ))
    else $error("accepted word not followed by memory read");

  a_valid_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == bsg_pkg::ST_UPDATE))
    else $error("result raised outside update");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> !(out_valid_r && out_stall))
    else $error("update while stalled result pending");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != bsg_pkg::ST_IDLE) |-> in_stall)
    else $error("input open while a word is in flight");
`endif

endmodule

[rtl/bsg_dp.sv]
module bsg_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bsg_pkg::cfg_t                         cfg,
  input  bsg_pkg::cmd_t                         cmd,
  output bsg_pkg::stat_t                        stat,
  input  logic signed [bsg_pkg::SAMPLE_BITS-1:0] in_sample_i,
  input  logic signed [bsg_pkg::SAMPLE_BITS-1:0] in_sample_q,
  output logic signed [bsg_pkg::SAMPLE_BITS-1:0] out_i,
  output logic signed [bsg_pkg::SAMPLE_BITS-1:0] out_q,
  output logic                                  out_squelched,
  output logic                                  out_last_of_block
);

  // control state
  logic [bsg_pkg::IDX_W-1:0] write_index_r;
  logic                      bank_r;
  logic [bsg_pkg::PWR_W-1:0] power_sum_r;
  bsg_pkg::mode_t            replay_mode_r;
  logic                      replay_squelched_r;
  logic                      gate_running_r;
  logic                      primed_r;

  // per-word working registers
  logic signed [bsg_pkg::SAMPLE_BITS-1:0] sample_i_r, sample_q_r;
  logic [bsg_pkg::GAIN_W-1:0]             gain_r;
  logic signed [bsg_pkg::PROD_W-1:0]      prod_i_r, prod_q_r;
  logic [bsg_pkg::SQ_W-1:0]               sq_i_r, sq_q_r;

  // result registers
  logic signed [bsg_pkg::SAMPLE_BITS-1:0] out_i_r, out_q_r;
  logic                                   squelched_r, last_r;

  logic [bsg_pkg::CMP_W-1:0]     blen, len_eff, idx_ext;
  logic                          last, in_ramp;
  logic [bsg_pkg::GPROD_W-1:0]   gprod;
  logic [bsg_pkg::GAIN_W-1:0]    gain_sat, gain_sel;
  logic [bsg_pkg::ADDR_W-1:0]    waddr, raddr;
  logic [bsg_pkg::WORD_W-1:0]    rdata;
  logic signed [bsg_pkg::SAMPLE_BITS-1:0] rd_i, rd_q;
  logic signed [bsg_pkg::GAIN_W:0]        gain_s;
  logic [bsg_pkg::PWR_W-1:0]     psum_new;
  logic                          squelch_now;

  assign idx_ext = bsg_pkg::CMP_W'(write_index_r);
  assign blen    = bsg_pkg::CMP_W'(cfg.block_len);

  always_comb begin
    if (blen == '0) begin
      len_eff = bsg_pkg::CMP_W'(1);
    end else if (blen > bsg_pkg::CMP_W'(bsg_pkg::BLOCK_DEPTH)) begin
      len_eff = bsg_pkg::CMP_W'(bsg_pkg::BLOCK_DEPTH);
    end else begin
      len_eff = blen;
    end
  end

  assign last    = (idx_ext + bsg_pkg::CMP_W'(1)) >= len_eff;
  assign in_ramp = idx_ext < bsg_pkg::CMP_W'(cfg.ramp_len);

  // ramp gain at this position, saturated at unity
  assign gprod = bsg_pkg::GPROD_W'(write_index_r) * bsg_pkg::GPROD_W'(cfg.ramp_recip);
  assign gain_sat = (gprod > bsg_pkg::GPROD_W'(bsg_pkg::GAIN_ONE)) ?
                    bsg_pkg::GAIN_ONE : gprod[bsg_pkg::GAIN_W-1:0];

  always_comb begin
    case (replay_mode_r)
      bsg_pkg::MODE_PASS:     gain_sel = bsg_pkg::GAIN_ONE;
      bsg_pkg::MODE_FADE_OUT: gain_sel = in_ramp ? (bsg_pkg::GAIN_ONE - gain_r) : '0;
      bsg_pkg::MODE_ZERO:     gain_sel = '0;
      bsg_pkg::MODE_FADE_IN:  gain_sel = in_ramp ? gain_r : bsg_pkg::GAIN_ONE;
      default:                gain_sel = bsg_pkg::GAIN_ONE;
    endcase
  end

  assign gain_s = $signed({1'b0, gain_sel});

  // bank being loaded takes the new word, the other bank replays
  assign waddr = {bank_r, write_index_r};
  assign raddr = {~bank_r, write_index_r};

  bsg_ram #(
    .WIDTH(bsg_pkg::WORD_W),
    .DEPTH(bsg_pkg::RAM_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.accept),
    .waddr(waddr),
    .wdata({in_sample_i, in_sample_q}),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_i = $signed(rdata[bsg_pkg::WORD_W-1:bsg_pkg::SAMPLE_BITS]);
  assign rd_q = $signed(rdata[bsg_pkg::SAMPLE_BITS-1:0]);

  assign psum_new = power_sum_r + bsg_pkg::PWR_W'(sq_i_r) + bsg_pkg::PWR_W'(sq_q_r);
  assign squelch_now = cfg.gate_enable &&
                       (bsg_pkg::PCMP_W'(cfg.threshold_power) > bsg_pkg::PCMP_W'(psum_new));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_i_r <= in_sample_i;
      sample_q_r <= in_sample_q;
      gain_r     <= gain_sat;
    end
    if (cmd.compute) begin
      prod_i_r <= rd_i * gain_s;
      prod_q_r <= rd_q * gain_s;
      sq_i_r   <= $unsigned(bsg_pkg::SQ_W'(sample_i_r) * bsg_pkg::SQ_W'(sample_i_r));
      sq_q_r   <= $unsigned(bsg_pkg::SQ_W'(sample_q_r) * bsg_pkg::SQ_W'(sample_q_r));
    end
    if (cmd.update && primed_r) begin
      // shift by the gain fraction, floor rounding
      out_i_r     <= prod_i_r[bsg_pkg::GAIN_FRAC +: bsg_pkg::SAMPLE_BITS];
      out_q_r     <= prod_q_r[bsg_pkg::GAIN_FRAC +: bsg_pkg::SAMPLE_BITS];
      squelched_r <= replay_squelched_r;
      last_r      <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_index_r      <= '0;
      bank_r             <= 1'b0;
      power_sum_r        <= '0;
      replay_mode_r      <= bsg_pkg::MODE_PASS;
      replay_squelched_r <= 1'b0;
      gate_running_r     <= 1'b0;
      primed_r           <= 1'b0;
    end else if (cmd.update) begin
      if (last) begin
        if (squelch_now) begin
          replay_squelched_r <= 1'b1;
          replay_mode_r      <= gate_running_r ? bsg_pkg::MODE_ZERO : bsg_pkg::MODE_FADE_OUT;
          gate_running_r     <= 1'b1;
        end else begin
          replay_squelched_r <= 1'b0;
          replay_mode_r      <= gate_running_r ? bsg_pkg::MODE_FADE_IN : bsg_pkg::MODE_PASS;
          gate_running_r     <= 1'b0;
        end
        power_sum_r   <= '0;
        bank_r        <= ~bank_r;
        write_index_r <= '0;
        primed_r      <= 1'b1;
      end else begin
        power_sum_r   <= psum_new;
        write_index_r <= write_index_r + bsg_pkg::IDX_W'(1);
      end
    end
  end

  assign stat.primed       = primed_r;
  assign out_i             = out_i_r;
  assign out_q             = out_q_r;
  assign out_squelched     = squelched_r;
  assign out_last_of_block = last_r;

endmodule

[rtl/block_squelch_gate_with_slew_unit.sv]
// Block power squelch with fade ramps. Complex samples are loaded into one bank of a
// ping-pong store while i*i+q*q is summed; at each block end the block is judged
// squelched when the gate is enabled and threshold_power exceeds the block power. Each
// result word is the sample at the same position of the previous block, passed, faded
// out, zeroed or faded in. No result comes out until the first block is complete. Each
// word passes accept and store access, multiply, then power update and result load; no
// new word is taken before the last is through, and a stall on the result side holds the
// update step until the output register is free. The store needs no clearing after reset.
module block_squelch_gate_with_slew_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [bsg_pkg::SAMPLE_BITS-1:0] in_sample_i,
  input  logic signed [bsg_pkg::SAMPLE_BITS-1:0] in_sample_q,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [bsg_pkg::SAMPLE_BITS-1:0] out_i,
  output logic signed [bsg_pkg::SAMPLE_BITS-1:0] out_q,
  output logic                                   out_squelched,
  output logic                                   out_last_of_block,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bsg_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [bsg_pkg::CFG_DATA_W-1:0]         cfg_data
);

  bsg_pkg::cfg_t  cfg_r;
  bsg_pkg::cmd_t  cmd;
  bsg_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gate_enable     <= 1'b0;
      cfg_r.threshold_power <= bsg_pkg::THRESHOLD_RESET;
      cfg_r.block_len       <= bsg_pkg::BLOCK_LEN_RESET;
      cfg_r.ramp_len        <= bsg_pkg::RAMP_LEN_RESET;
      cfg_r.ramp_recip      <= bsg_pkg::RAMP_RECIP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bsg_pkg::CFG_GATE_ENABLE:     cfg_r.gate_enable     <= cfg_data[0];
        bsg_pkg::CFG_THRESHOLD_POWER: cfg_r.threshold_power <= cfg_data[bsg_pkg::THR_W-1:0];
        bsg_pkg::CFG_BLOCK_LEN:       cfg_r.block_len       <= cfg_data[bsg_pkg::LEN_W-1:0];
        bsg_pkg::CFG_RAMP_LEN:        cfg_r.ramp_len        <= cfg_data[bsg_pkg::LEN_W-1:0];
        bsg_pkg::CFG_RAMP_RECIP:      cfg_r.ramp_recip      <= cfg_data[bsg_pkg::RECIP_W-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  bsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsg_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .stat             (stat),
    .in_sample_i      (in_sample_i),
    .in_sample_q      (in_sample_q),
    .out_i            (out_i),
    .out_q            (out_q),
    .out_squelched    (out_squelched),
    .out_last_of_block(out_last_of_block)
  );

endmodule
